// ===== hw/rtl/mps_pkg.sv =====
// Package for the mean pool sigmoid block: types, register codes and sigmoid table.
package mps_pkg;

	typedef enum logic [2:0] {
		REG_KERNEL_ROWS = 3'd0,
		REG_KERNEL_COLS = 3'd1,
		REG_INPUT_WIDTH = 3'd2,
		REG_INPUT_HEIGHT = 3'd3,
		REG_WINDOW_RECIP = 3'd4,
		REG_MAP_COUNT = 3'd5
	} reg_index_t;

	localparam int SUM_W = 22;

	typedef struct packed {
		logic load;      // register a new pixel into the datapath
		logic advance;   // move stage 1 to stage 2
		logic finish;    // move stage 2 to the output register
		logic out_take;  // output register drained
	} mps_cmd_t;

	typedef struct packed {
		logic s1_emit;
		logic out_full;
	} mps_status_t;

	function automatic logic [16:0] sig_entry(input logic [4:0] k);
		logic [16:0] v;
		case (k)
			5'd0: v = 17'd32768;
			5'd1: v = 17'd40793;
			5'd2: v = 17'd47911;
			5'd3: v = 17'd53581;
			5'd4: v = 17'd57724;
			5'd5: v = 17'd60565;
			5'd6: v = 17'd62428;
			5'd7: v = 17'd63615;
			5'd8: v = 17'd64357;
			5'd9: v = 17'd64816;
			5'd10: v = 17'd65097;
			5'd11: v = 17'd65269;
			5'd12: v = 17'd65374;
			5'd13: v = 17'd65438;
			5'd14: v = 17'd65476;
			5'd15: v = 17'd65501;
			5'd16: v = 17'd65514;
			default: v = 17'd65514;
		endcase
		return v;
	endfunction

endpackage

// ===== hw/rtl/mean_pool_sigmoid.sv =====
// Top level of the mean pool sigmoid block.
// After the pixel transfer that completes a window, out_valid rises once the scale and
// sigmoid states have passed; sigmoid holds while a prior result awaits out_ready.
// Pixels are taken only in idle; column read, multiply and sigmoid run in sequence.
// Reset: arst_n clears counters, row sum and output valid and restores the
// register reset values; the column store is left unset.
module mean_pool_sigmoid #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_KERNEL = 8,
	parameter int MAX_OUT_WIDTH = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] pixel,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        activation,
	output logic               last_of_map,
	output logic               last_of_layer
);

	logic [3:0]  kernel_rows_q, kernel_cols_q;
	logic [10:0] input_width_q, input_height_q;
	logic [15:0] window_reciprocal_q;
	logic [8:0]  map_count_q;
	logic [2:0]  reg_idx;

	assign pready = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_rows_q <= 4'd2;
			kernel_cols_q <= 4'd2;
			input_width_q <= 11'd28;
			input_height_q <= 11'd28;
			window_reciprocal_q <= 16'd16384;
			map_count_q <= 9'd1;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			case (reg_idx)
				mps_pkg::REG_KERNEL_ROWS: kernel_rows_q <= pwdata[3:0];
				mps_pkg::REG_KERNEL_COLS: kernel_cols_q <= pwdata[3:0];
				mps_pkg::REG_INPUT_WIDTH: input_width_q <= pwdata[10:0];
				mps_pkg::REG_INPUT_HEIGHT: input_height_q <= pwdata[10:0];
				mps_pkg::REG_WINDOW_RECIP: window_reciprocal_q <= pwdata[15:0];
				mps_pkg::REG_MAP_COUNT: map_count_q <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			mps_pkg::REG_KERNEL_ROWS: prdata = 32'(kernel_rows_q);
			mps_pkg::REG_KERNEL_COLS: prdata = 32'(kernel_cols_q);
			mps_pkg::REG_INPUT_WIDTH: prdata = 32'(input_width_q);
			mps_pkg::REG_INPUT_HEIGHT: prdata = 32'(input_height_q);
			mps_pkg::REG_WINDOW_RECIP: prdata = 32'(window_reciprocal_q);
			mps_pkg::REG_MAP_COUNT: prdata = 32'(map_count_q);
			default: prdata = 32'd0;
		endcase
	end

	mps_pkg::mps_cmd_t    cmd;
	mps_pkg::mps_status_t status;

	mps_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .cmd(cmd)
	);

	mps_datapath #(
		.MAX_WIDTH(MAX_WIDTH), .MAX_KERNEL(MAX_KERNEL), .MAX_OUT_WIDTH(MAX_OUT_WIDTH)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status), .pixel(pixel),
		.kernel_rows(kernel_rows_q), .kernel_cols(kernel_cols_q),
		.input_width(input_width_q), .input_height(input_height_q),
		.window_reciprocal(window_reciprocal_q), .map_count(map_count_q),
		.activation(activation), .last_of_map(last_of_map),
		.last_of_layer(last_of_layer)
	);

endmodule

// ===== hw/rtl/mps_ctrl.sv =====
// Controller for the mean pool sigmoid block: sequences load, scale and output.
module mps_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  mps_pkg::mps_status_t status,
	output mps_pkg::mps_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCALE,
		ST_SIG
	} state_t;

	state_t state_q;
	logic   take;

	assign take = out_valid && out_ready;
	assign out_valid = status.out_full;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd.load = (state_q == ST_IDLE) && in_valid;
		cmd.advance = (state_q == ST_SCALE);
		cmd.finish = (state_q == ST_SIG) && (!status.out_full || take);
		cmd.out_take = take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					if (status.s1_emit) state_q <= ST_SIG;
					else state_q <= ST_IDLE;
				end
				ST_SIG: begin
					if (cmd.finish) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/mps_datapath.sv =====
// Datapath for the mean pool sigmoid block: counters, column store, scale and sigmoid.
module mps_datapath #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_KERNEL = 8,
	parameter int MAX_OUT_WIDTH = 512
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mps_pkg::mps_cmd_t    cmd,
	output mps_pkg::mps_status_t status,
	input  logic signed [15:0]   pixel,
	input  logic [3:0]           kernel_rows,
	input  logic [3:0]           kernel_cols,
	input  logic [10:0]          input_width,
	input  logic [10:0]          input_height,
	input  logic [15:0]          window_reciprocal,
	input  logic [8:0]           map_count,
	output logic [15:0]          activation,
	output logic                 last_of_map,
	output logic                 last_of_layer
);

	localparam int PW = $clog2(MAX_WIDTH);
	localparam int KW = $clog2(MAX_KERNEL + 1);
	localparam int OW = $clog2(MAX_OUT_WIDTH);
	localparam int CW = PW + 1;
	localparam int SW = mps_pkg::SUM_W;

	// Divide by a kernel size through a rounded-up reciprocal of 2^17.
	function automatic logic [CW-1:0] div_k(input logic [CW-1:0] x, input logic [KW-1:0] k);
		logic [17:0]    c;
		logic [CW+17:0] p;
		case (5'(k))
			5'd2: c = 18'd65536;
			5'd3: c = 18'd43691;
			5'd4: c = 18'd32768;
			5'd5: c = 18'd26215;
			5'd6: c = 18'd21846;
			5'd7: c = 18'd18725;
			5'd8: c = 18'd16384;
			5'd9: c = 18'd14564;
			5'd10: c = 18'd13108;
			5'd11: c = 18'd11916;
			5'd12: c = 18'd10923;
			5'd13: c = 18'd10083;
			5'd14: c = 18'd9363;
			5'd15: c = 18'd8739;
			5'd16: c = 18'd8192;
			default: c = 18'd131072;
		endcase
		p = (CW+18)'(x) * (CW+18)'(c);
		return p[CW+16:17];
	endfunction

	logic [KW-1:0] kr, kc;
	logic [CW-1:0] w, h;
	logic [8:0]    maps;

	always_comb begin
		kr = (kernel_rows == 4'd0) ? KW'(1) :
			(32'(kernel_rows) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(kernel_rows);
		kc = (kernel_cols == 4'd0) ? KW'(1) :
			(32'(kernel_cols) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(kernel_cols);
		w = (input_width == 11'd0) ? CW'(1) :
			(32'(input_width) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(input_width);
		h = (input_height == 11'd0) ? CW'(1) :
			(32'(input_height) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(input_height);
		maps = (map_count == 9'd0) ? 9'd1 : (map_count > 9'd256) ? 9'd256 : map_count;
	end

	logic [PW-1:0] pcol_q, prow_q;
	logic [KW-1:0] riw_q, ciw_q;
	logic [7:0]    map_q;
	logic signed [SW-1:0] row_sum_q;
	logic signed [SW-1:0] col_mem [MAX_OUT_WIDTH];

	logic [CW-1:0] oc, orow, nc_div, nc_lim, nr_lim;
	always_comb begin
		oc = div_k(CW'(pcol_q), kc);
		orow = div_k(CW'(prow_q), kr);
		nc_div = div_k(w, kc);
		nc_lim = (32'(nc_div) > MAX_OUT_WIDTH) ? CW'(MAX_OUT_WIDTH) : nc_div;
		nr_lim = div_k(h, kr);
	end

	logic col_end, row_last, row_end, active;
	logic signed [SW-1:0] new_row, total;
	logic signed [SW-1:0] col_rd_q;
	logic signed [15:0] pix_s1;
	logic active_s1, col_end_s1, clr_s1, first_row_s1, emit_s1, lm_s1, ll_s1;
	logic [OW-1:0] oc_s1;
	logic signed [SW-1:0] rsum_s1;

	// Stage 1: capture pixel and read column sum.
	always_comb begin
		col_end = (32'(ciw_q) + 1 >= 32'(kc));
		row_last = (32'(riw_q) + 1 >= 32'(kr));
		row_end = (32'(pcol_q) + 1 >= 32'(w));
		active = (oc < nc_lim) && (orow < nr_lim);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pix_s1 <= pixel;
			oc_s1 <= OW'(oc);
			rsum_s1 <= row_sum_q;
			active_s1 <= active;
			col_end_s1 <= col_end;
			clr_s1 <= col_end || row_end;
			first_row_s1 <= (riw_q == '0);
			emit_s1 <= active && col_end && row_last;
			lm_s1 <= (oc + CW'(1) == nc_lim) && (orow + CW'(1) == nr_lim);
			ll_s1 <= (32'(map_q) + 1 >= 32'(maps));
			col_rd_q <= col_mem[OW'(oc)];
		end
	end

	always_comb begin
		new_row = rsum_s1 + SW'(pix_s1);
		total = first_row_s1 ? new_row : col_rd_q + new_row;
	end

	logic signed [SW+16:0] prod_s2;
	logic lm_s2, ll_s2;

	always_ff @(posedge clk) begin
		if (cmd.advance) begin
			if (active_s1 && col_end_s1) col_mem[oc_s1] <= total;
			prod_s2 <= total * $signed({1'b0, window_reciprocal});
			lm_s2 <= lm_s1;
			ll_s2 <= lm_s1 && ll_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_sum_q <= '0;
		end else if (cmd.advance) begin
			if (clr_s1) row_sum_q <= '0;
			else if (active_s1) row_sum_q <= new_row;
		end
	end

	// Counters advance on load.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcol_q <= '0; prow_q <= '0; riw_q <= '0; ciw_q <= '0; map_q <= '0;
		end else if (cmd.load) begin
			if (col_end) ciw_q <= '0;
			else ciw_q <= ciw_q + KW'(1);
			if (row_end) begin
				pcol_q <= '0; ciw_q <= '0;
				if (row_last) riw_q <= '0;
				else riw_q <= riw_q + KW'(1);
				if (32'(prow_q) + 1 >= 32'(h)) begin
					prow_q <= '0; riw_q <= '0;
					if (32'(map_q) + 1 >= 32'(maps)) map_q <= '0;
					else map_q <= map_q + 8'd1;
				end else begin
					prow_q <= prow_q + PW'(1);
				end
			end else begin
				pcol_q <= pcol_q + PW'(1);
			end
		end
	end

	// Stage 3: round, saturate, sigmoid.
	logic signed [SW+16:0] rnd;
	logic signed [SW:0] m_full;
	logic signed [15:0] m;
	logic [15:0] a;
	logic [3:0] ti;
	logic [6:0] tf;
	logic [16:0] t0, t1, y;
	logic [23:0] slope;
	logic out_full_q;
	logic [15:0] act_q;
	logic lm_q, ll_q;

	always_comb begin
		rnd = prod_s2 + (SW+17)'(32768);
		m_full = rnd[SW+16:16];
		if (m_full > 32767) m = 16'sd32767;
		else if (m_full < -32768) m = -16'sd32768;
		else m = m_full[15:0];
		a = m[15] ? 16'(-17'(m)) : m;
		ti = a[10:7];
		tf = a[6:0];
		t0 = mps_pkg::sig_entry({1'b0, ti});
		t1 = mps_pkg::sig_entry(5'({1'b0, ti}) + 5'd1);
		slope = 24'(t1 - t0) * 24'(tf) + 24'd64;
		if (a >= 16'd2048) y = mps_pkg::sig_entry(5'd16);
		else y = t0 + 17'(slope[23:7]);
		if (m[15]) y = 17'd65536 - y;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			act_q <= y[15:0];
			lm_q <= lm_s2;
			ll_q <= ll_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_full_q <= 1'b0;
		else if (cmd.finish) out_full_q <= 1'b1;
		else if (cmd.out_take) out_full_q <= 1'b0;
	end

	assign status.s1_emit = emit_s1;
	assign status.out_full = out_full_q;
	assign activation = act_q;
	assign last_of_map = lm_q;
	assign last_of_layer = ll_q;

endmodule
